// ===== hdl/qpr_pkg.sv =====
// Shared constants, types and term tables for the quaternion product and rotation block.
// Used by qpr_pass and quaternion_product_rotate; depends on nothing else.
package qpr_pkg;

    localparam int DW   = 32;
    localparam int NQ   = 4;
    localparam int FRAC = 16;
    localparam int HALF = 32768;
    localparam int CW   = DW + 1;

    typedef enum logic {
        KIND_PRODUCT = 1'b0,
        KIND_ROTATE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [NQ-1:0][DW-1:0]   vec;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    // Index into q of term j of result component k in a Hamilton product p*q.
    function automatic logic [1:0] q_index(input int k, input int j);
        logic [1:0] idx;
        case ({k[1:0], j[1:0]})
            4'b0000: idx = 2'd0;
            4'b0001: idx = 2'd1;
            4'b0010: idx = 2'd2;
            4'b0011: idx = 2'd3;
            4'b0100: idx = 2'd1;
            4'b0101: idx = 2'd0;
            4'b0110: idx = 2'd3;
            4'b0111: idx = 2'd2;
            4'b1000: idx = 2'd2;
            4'b1001: idx = 2'd3;
            4'b1010: idx = 2'd0;
            4'b1011: idx = 2'd1;
            4'b1100: idx = 2'd3;
            4'b1101: idx = 2'd2;
            4'b1110: idx = 2'd1;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

    // True where term j of result component k enters the sum with a minus sign.
    function automatic logic term_neg(input int k, input int j);
        logic neg;
        case ({k[1:0], j[1:0]})
            4'b0001, 4'b0010, 4'b0011,
            4'b0111, 4'b1001, 4'b1110: neg = 1'b1;
            default:                   neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

// ===== hdl/quaternion_product_rotate.sv =====
// Quaternion Hamilton product and vector rotation in signed Q16.16, top level.
// Depends on qpr_pkg and qpr_pass.
//
// Each transaction carries a kind and two quaternions. Kind 0 returns the Hamilton product
// a*b; kind 1 returns the vector part of a*(0,v)*conj(a) with v = (b_x, b_y, b_z) and
// res_w zero, without normalizing a. Every product is rounded to nearest (ties toward plus
// infinity) and every component saturates to 32 bits. The block takes one transaction per
// clock unless all stages are full and the output blocked. Each result goes through two
// product passes of three register stages each (multiply, round, sum and saturate), the
// second doing the conjugate multiply for rotations. Every stage holds its own valid bit,
// so bubbles close up under a blocked output, and no state is kept between transactions.
module quaternion_product_rotate (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic signed [qpr_pkg::DW-1:0] s_a_w,
    input  logic signed [qpr_pkg::DW-1:0] s_a_x,
    input  logic signed [qpr_pkg::DW-1:0] s_a_y,
    input  logic signed [qpr_pkg::DW-1:0] s_a_z,
    input  logic signed [qpr_pkg::DW-1:0] s_b_w,
    input  logic signed [qpr_pkg::DW-1:0] s_b_x,
    input  logic signed [qpr_pkg::DW-1:0] s_b_y,
    input  logic signed [qpr_pkg::DW-1:0] s_b_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [qpr_pkg::DW-1:0] m_res_w,
    output logic signed [qpr_pkg::DW-1:0] m_res_x,
    output logic signed [qpr_pkg::DW-1:0] m_res_y,
    output logic signed [qpr_pkg::DW-1:0] m_res_z
);

    localparam int NQ = qpr_pkg::NQ;
    localparam int DW = qpr_pkg::DW;
    localparam int CW = qpr_pkg::CW;

    logic signed [DW-1:0] p1_p [NQ];
    logic signed [DW-1:0] p1_q [NQ];
    logic signed [DW-1:0] p1_r [NQ];
    logic signed [CW-1:0] p2_q [NQ];
    logic signed [DW-1:0] p2_r [NQ];
    qpr_pkg::side_t       side_in, side1, side_mid, side2;
    logic                 p1_valid, p2_ready;
    logic                 rotate;

    always_comb begin
        p1_p[0] = s_a_w;
        p1_p[1] = s_a_x;
        p1_p[2] = s_a_y;
        p1_p[3] = s_a_z;
        p1_q[0] = (qpr_pkg::kind_t'(s_kind) == qpr_pkg::KIND_ROTATE) ? '0 : s_b_w;
        p1_q[1] = s_b_x;
        p1_q[2] = s_b_y;
        p1_q[3] = s_b_z;
        side_in.kind = qpr_pkg::kind_t'(s_kind);
        side_in.vec  = {s_a_z, s_a_y, s_a_x, s_a_w};
    end

    qpr_pass #(
        .PW(DW),
        .QW(DW)
    ) u_pass1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_p     (p1_p),
        .in_q     (p1_q),
        .in_side  (side_in),
        .out_valid(p1_valid),
        .out_ready(p2_ready),
        .out_r    (p1_r),
        .out_side (side1)
    );

    always_comb begin
        p2_q[0] = $signed({side1.vec[0][DW-1], side1.vec[0]});
        for (int i = 1; i < NQ; i++) begin
            p2_q[i] = -$signed({side1.vec[i][DW-1], side1.vec[i]});
        end
        side_mid.kind = side1.kind;
        side_mid.vec  = {p1_r[3], p1_r[2], p1_r[1], p1_r[0]};
    end

    qpr_pass #(
        .PW(DW),
        .QW(CW)
    ) u_pass2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p1_valid),
        .in_ready (p2_ready),
        .in_p     (p1_r),
        .in_q     (p2_q),
        .in_side  (side_mid),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_r    (p2_r),
        .out_side (side2)
    );

    assign rotate  = (side2.kind == qpr_pkg::KIND_ROTATE);
    assign m_res_w = rotate ? '0      : $signed(side2.vec[0]);
    assign m_res_x = rotate ? p2_r[1] : $signed(side2.vec[1]);
    assign m_res_y = rotate ? p2_r[2] : $signed(side2.vec[2]);
    assign m_res_z = rotate ? p2_r[3] : $signed(side2.vec[3]);

endmodule

// ===== hdl/qpr_pass.sv =====
// One Hamilton product pass in three register stages: multiply, round, sum and saturate.
// Depends on qpr_pkg; instantiated twice by quaternion_product_rotate.
module qpr_pass #(
    parameter int PW = qpr_pkg::DW,
    parameter int QW = qpr_pkg::DW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [PW-1:0]          in_p [qpr_pkg::NQ],
    input  logic signed [QW-1:0]          in_q [qpr_pkg::NQ],
    input  qpr_pkg::side_t                in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [qpr_pkg::DW-1:0] out_r [qpr_pkg::NQ],
    output qpr_pkg::side_t                out_side
);

    localparam int NQ  = qpr_pkg::NQ;
    localparam int DW  = qpr_pkg::DW;
    localparam int PRW = PW + QW;
    localparam int RW  = PRW - qpr_pkg::FRAC + 1;
    localparam int SW  = RW + 2;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [PRW-1:0]  prod_reg  [NQ][NQ];
    logic signed [PRW-1:0]  prod_next [NQ][NQ];
    logic signed [RW-1:0]   rnd_reg   [NQ][NQ];
    logic signed [RW-1:0]   rnd_next  [NQ][NQ];
    logic [NQ-1:0][DW-1:0]  res_reg;
    logic [NQ-1:0][DW-1:0]  res_next;
    qpr_pkg::side_t         side1_reg, side2_reg, side3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin : mul_stage
        for (int k = 0; k < NQ; k++) begin
            for (int j = 0; j < NQ; j++) begin
                prod_next[k][j] = in_p[j] * in_q[qpr_pkg::q_index(k, j)];
            end
        end
    end

    always_comb begin : round_stage
        logic signed [PRW-1:0] tmp;
        logic signed [RW-1:0]  rv;
        tmp = '0;
        rv  = '0;
        for (int k = 0; k < NQ; k++) begin
            for (int j = 0; j < NQ; j++) begin
                tmp = prod_reg[k][j] + PRW'(qpr_pkg::HALF);
                rv  = $signed(tmp[PRW-1:qpr_pkg::FRAC]);
                rnd_next[k][j] = qpr_pkg::term_neg(k, j) ? -rv : rv;
            end
        end
    end

    always_comb begin : sum_stage
        logic signed [SW-1:0] sum;
        sum = '0;
        for (int k = 0; k < NQ; k++) begin
            sum = rnd_reg[k][0] + rnd_reg[k][1] + rnd_reg[k][2] + rnd_reg[k][3];
            if ((&sum[SW-1:DW-1]) || !(|sum[SW-1:DW-1])) begin
                res_next[k] = sum[DW-1:0];
            end else if (sum[SW-1]) begin
                res_next[k] = {1'b1, {(DW-1){1'b0}}};
            end else begin
                res_next[k] = {1'b0, {(DW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            prod_reg  <= prod_next;
            side1_reg <= in_side;
        end
        if (en2 && v1_reg) begin
            rnd_reg   <= rnd_next;
            side2_reg <= side1_reg;
        end
        if (en3 && v2_reg) begin
            res_reg   <= res_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;

    always_comb begin
        for (int k = 0; k < NQ; k++) begin
            out_r[k] = $signed(res_reg[k]);
        end
    end

    // The input stalls only when every stage holds a transaction and the output is blocked.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && !out_ready))
        else $error("qpr_pass stalled with a free stage");

    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> v1_reg)
        else $error("qpr_pass lost an accepted transaction");

    a_stage1_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en2) |=> v2_reg)
        else $error("qpr_pass dropped a transaction between stages");

    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !out_ready) |=> (v3_reg && $stable(res_reg) && $stable(side3_reg)))
        else $error("qpr_pass changed a blocked result");

endmodule
